[sv/mbps_pkg.sv]
// mbps_pkg: shared types and constants for the masked byte pattern search
// word structs, configuration register map, and window sizing
// no dependencies
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;
  localparam int LEN_BITS          = 5;
  localparam int ADDR_BITS         = 5;
  localparam int DATA_BITS         = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_CARE_MASK    = 2'd2,
    REG_PATTERN_LEN  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } result_word_t;

  typedef struct packed {
    logic [63:0]                  pattern_low;
    logic [63:0]                  pattern_high;
    logic [MAX_PATTERN_BYTES-1:0] care_mask;
    logic [LEN_BITS-1:0]          pattern_length;
  } cfg_t;

  typedef struct packed {
    logic         hit;
    result_word_t word;
  } match_out_t;

endpackage

[sv/mbps_cfg.sv]
// mbps_cfg: APB-style configuration registers for the pattern search
// holds pattern bytes, care mask and pattern length
// depends on mbps_pkg
module mbps_cfg import mbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  reg_index_t reg_index;
  logic       wr_en;

  assign reg_index = reg_index_t'(paddr[ADDR_BITS-1:3]);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.care_mask      <= '1;
      cfg.pattern_length <= LEN_BITS'(1);
    end else if (wr_en) begin
      unique case (reg_index)
        REG_PATTERN_LOW:  cfg.pattern_low    <= pwdata;
        REG_PATTERN_HIGH: cfg.pattern_high   <= pwdata;
        REG_CARE_MASK:    cfg.care_mask      <= pwdata[MAX_PATTERN_BYTES-1:0];
        REG_PATTERN_LEN:  cfg.pattern_length <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PATTERN_LOW:  prdata = cfg.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg.pattern_high;
      REG_CARE_MASK:    prdata = DATA_BITS'(cfg.care_mask);
      REG_PATTERN_LEN:  prdata = DATA_BITS'(cfg.pattern_length);
      default:          prdata = '0;
    endcase
  end

endmodule

[sv/mbps_match.sv]
// mbps_match: byte window, region counters and masked window compare
// produces at most one result per accepted byte
// depends on mbps_pkg
module mbps_match import mbps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_word_t word,
  input  cfg_t       cfg,
  output match_out_t result
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = '1;

  logic [7:0]             recent_bytes [MAX_PATTERN_BYTES];
  logic [7:0]             recent_bytes_next [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   already_reported;

  logic [7:0]             pat [MAX_PATTERN_BYTES];
  logic [LEN_BITS-1:0]    len;
  logic [LEN_BITS-1:0]    len_m1;
  logic [MAX_PATTERN_BYTES-1:0] len_match;
  logic                   win_match;
  logic                   searching;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start_offset;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < 8) pat[i] = cfg.pattern_low[8*(i%8) +: 8];
      else       pat[i] = cfg.pattern_high[8*(i%8) +: 8];
    end
  end

  // clamp length into 1..max
  always_comb begin
    if (cfg.pattern_length == '0)
      len = LEN_BITS'(1);
    else if (cfg.pattern_length > LEN_BITS'(MAX_PATTERN_BYTES))
      len = LEN_BITS'(MAX_PATTERN_BYTES);
    else
      len = cfg.pattern_length;
    len_m1 = len - LEN_BITS'(1);
  end

  always_comb begin
    recent_bytes_next[0] = word.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++)
      recent_bytes_next[k] = recent_bytes[k-1];
  end

  // one match bit per candidate length, fixed window taps
  always_comb begin
    for (int l = 0; l < MAX_PATTERN_BYTES; l++) begin
      len_match[l] = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        if (i <= l) begin
          if (cfg.care_mask[i] && (recent_bytes_next[l-i] != pat[i]))
            len_match[l] = 1'b0;
        end
      end
    end
  end

  assign win_match    = len_match[len_m1[LEN_BITS-2:0]];
  assign searching    = bytes_seen < OFFSET_LIMIT;
  assign hit          = searching && !already_reported &&
                        (bytes_seen >= OFFSET_BITS'(len_m1)) && win_match;
  assign start_offset = bytes_seen - OFFSET_BITS'(len_m1);

  always_comb begin
    result.hit = 1'b0;
    result.word.found = 1'b0;
    result.word.match_offset = '0;
    if (hit) begin
      result.hit = 1'b1;
      result.word.found = 1'b1;
      result.word.match_offset = 32'(start_offset);
    end else if (word.last_byte && !already_reported) begin
      result.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= '0;
      already_reported <= 1'b0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) recent_bytes[k] <= '0;
    end else if (take) begin
      if (word.last_byte) begin
        bytes_seen       <= '0;
        already_reported <= 1'b0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) recent_bytes[k] <= '0;
      end else if (searching) begin
        bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        if (hit) already_reported <= 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) recent_bytes[k] <= recent_bytes_next[k];
      end
    end
  end

endmodule

[sv/masked_byte_pattern_search.sv]
// masked_byte_pattern_search: top level of the wildcard byte pattern scan
// channel   | valid         | stall         | word
// byte in   | byte_valid    | byte_stall    | byte_word (data_byte, last_byte)
// result    | result_valid  | result_stall  | result_word (found, match_offset)
// config    | psel/penable  | pready = 1    | paddr, pwdata, prdata (64 bit)
// one byte per cycle unless stalled; results register when their byte is taken
// byte_stall rises only while a held result is stalled downstream
// rst is synchronous and clears window, counters and result valid
// depends on mbps_pkg, mbps_cfg, mbps_match
module masked_byte_pattern_search import mbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  byte_word_t           byte_word,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_word_t         result_word,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t       cfg;
  match_out_t match_res;
  logic       take;

  assign byte_stall = result_valid && result_stall;
  assign take       = byte_valid && !byte_stall;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbps_match u_match (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (byte_word),
    .cfg    (cfg),
    .result (match_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && match_res.hit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && match_res.hit) begin
      result_word <= match_res.word;
    end
  end

endmodule

[sv/mbps_checker.sv]
// mbps_checker: port-level assertions for masked_byte_pattern_search
// bound to the top level below
// depends on mbps_pkg
module mbps_checker import mbps_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         byte_stall,
  input logic         result_valid,
  input logic         result_stall,
  input result_word_t result_word
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("stalled result word dropped or changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.found |-> result_word.match_offset == 32'd0)
    else $error("not-found result carries an offset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("byte input stalled without a blocked result");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);

[bench/masked_byte_pattern_search_test.sv]
// masked_byte_pattern_search_test: self-checking bench for the wildcard byte pattern scan
// drives byte words and apb register writes, predicts match reports in a scoreboard class
// depends on mbps_pkg and masked_byte_pattern_search
`timescale 1ns / 100ps

module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  class pattern_scan_scoreboard;
    logic [63:0]     pat_lo;
    logic [63:0]     pat_hi;
    logic [15:0]     care;
    logic [4:0]      plen;
    logic [7:0]      window [16];
    longint unsigned seen;
    bit              reported;
    result_word_t    expected_reports [$];
    int              errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      care = 16'hFFFF;
      plen = 5'd1;
      errors = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      seen = 0;
      reported = 0;
    endfunction

    function int active_len();
      if (plen == 0) return 1;
      if (plen > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
      return int'(plen);
    endfunction

    function logic [7:0] pat_byte(int i);
      return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    function void set_reg(reg_index_t idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_LOW: pat_lo = v;
        REG_PATTERN_HIGH: pat_hi = v;
        REG_CARE_MASK: care = v[15:0];
        REG_PATTERN_LEN: plen = v[4:0];
        default: ;
      endcase
    endfunction

    // window[0] is the newest byte; a match is tried at most once per byte taken
    function void note_byte(byte_word_t w);
      int len;
      bit hit;
      result_word_t r;
      len = active_len();
      if (seen < 64'hFFFF_FFFF) begin
        for (int k = 15; k > 0; k--) window[k] = window[k-1];
        window[0] = w.data_byte;
        if (!reported && seen >= len - 1) begin
          hit = 1;
          for (int i = 0; i < len; i++)
            if (care[i] && window[len-1-i] != pat_byte(i)) hit = 0;
          if (hit) begin
            r.found = 1'b1;
            r.match_offset = 32'(seen - (len - 1));
            expected_reports.push_back(r);
            reported = 1;
          end
        end
        seen++;
      end
      if (w.last_byte) begin
        if (!reported) begin
          r.found = 1'b0;
          r.match_offset = '0;
          expected_reports.push_back(r);
        end
        clear_region();
      end
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing pending, found %0b offset %0d",
                 $time, got.found, got.match_offset);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.match_offset !== want.match_offset) begin
        $display("%0t: match_offset expected %0d actual %0d",
                 $time, want.match_offset, got.match_offset);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_stall;
  byte_word_t           byte_word;
  logic                 result_valid;
  logic                 result_stall;
  result_word_t         result_word;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  pattern_scan_scoreboard sb;
  int send_idle;
  int recv_idle;

  masked_byte_pattern_search dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word(byte_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word(result_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic apb_write(reg_index_t idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [15:0] mask,
                           logic [4:0] len);
    apb_write(REG_PATTERN_LOW, lo);
    apb_write(REG_PATTERN_HIGH, hi);
    apb_write(REG_CARE_MASK, 64'(mask));
    apb_write(REG_PATTERN_LEN, 64'(len));
  endtask

  task automatic send_word(byte_word_t w);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word <= w;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(w);
  endtask

  task automatic send_byte(logic [7:0] d, logic last);
    byte_word_t w;
    w.data_byte = d;
    w.last_byte = last;
    send_word(w);
  endtask

  // noise, planted pattern with one byte flipped, or planted pattern
  task automatic send_region(int n, int mode);
    logic [7:0] region [64];
    int len;
    int pos;
    int k;
    len = sb.active_len();
    for (int i = 0; i < n; i++)
      region[i] = (mode >= 2 && $urandom_range(1) == 1) ?
                  sb.pat_byte($urandom_range(len - 1)) : 8'($urandom);
    if (mode >= 2 && n >= len) begin
      pos = $urandom_range(n - len);
      for (k = 0; k < len; k++)
        if (sb.care[k] || $urandom_range(1) == 1) region[pos+k] = sb.pat_byte(k);
      if (mode < 4) begin
        k = $urandom_range(len - 1);
        region[pos+k] ^= 8'(1 << $urandom_range(7));
      end
    end
    for (int i = 0; i < n; i++) send_byte(region[i], i == n - 1);
  endtask

  task automatic wait_drained();
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: checks results, random stalls, one long hold mid region
  initial begin
    int hold_left;
    int bytes_in;
    bit held_once;
    hold_left = 0;
    bytes_in = 0;
    held_once = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_valid && !result_stall) sb.check_result(result_word);
        if (byte_valid && !byte_stall) begin
          bytes_in++;
          if (!held_once && bytes_in >= 300 && !byte_word.last_byte) begin
            held_once = 1;
            hold_left = 120;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    int sent;
    int n;
    int mode;
    int len;
    sb = new();
    send_idle = 37;
    recv_idle = 73;
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one byte pattern of zero
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    byte_valid <= 1'b0;
    wait_drained();

    // three bytes, middle one wildcard
    configure(64'h0000_0000_00AA_55AA, 64'h0, 16'h0005, 5'd3);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    byte_valid <= 1'b0;
    wait_drained();

    // zero length acts as one
    configure(64'hFF, 64'h0, 16'hFFFF, 5'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    byte_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        send_idle = 37;
        recv_idle = 73;
      end else if (p < 6) begin
        send_idle = 73;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: configure({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16);
        1: configure('1, '1, 16'h0000, 5'd5);
        2: configure({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd31);
        3: configure({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd0);
        4: configure({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd17);
        5: configure('0, '0, 16'($urandom), 5'($urandom_range(1, 16)));
        default: configure({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                           5'($urandom_range(1, 16)));
      endcase
      len = sb.active_len();
      sent = 0;
      while (sent < 80) begin
        mode = $urandom_range(9);
        n = (mode < 2) ? $urandom_range(1, 24) : $urandom_range(len, len + 12);
        send_region(n, mode);
        sent += n;
      end
      byte_valid <= 1'b0;
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mbps_pkg.sv
sv/mbps_cfg.sv
sv/mbps_match.sv
sv/masked_byte_pattern_search.sv
sv/mbps_checker.sv
bench/masked_byte_pattern_search_test.sv
